[rtl/core/dsbcd_pkg.sv]
package dsbcd_pkg;

   localparam int SAMPLE_W          = 16;
   localparam int COEF_W            = 16;
   localparam int ENERGY_W          = 63;
   localparam int WINDOW_DEFAULT    = 1000;
   localparam int COS_DEPTH_DEFAULT = 256;

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN       = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PHASE_STEP = 1'd1;

   localparam logic [CSR_DATA_W-1:0] GAIN_RESET       = 16'd2560;
   localparam logic [CSR_DATA_W-1:0] PHASE_STEP_RESET = 16'd6554;

   localparam longint Q30_ONE     = 64'sd1073741824;
   localparam longint HALF_PI_Q30 = 64'sd1686629713;

   // Taylor term divide, (n+1)*(n+2) for term index n
   function automatic longint taylor_div(input longint t, input int n);
      longint q;
      case (n)
         0:  q = t / 2;
         1:  q = t / 6;
         2:  q = t / 12;
         3:  q = t / 20;
         4:  q = t / 30;
         5:  q = t / 42;
         6:  q = t / 56;
         7:  q = t / 72;
         8:  q = t / 90;
         9:  q = t / 110;
         10: q = t / 132;
         11: q = t / 156;
         12: q = t / 182;
         13: q = t / 210;
         14: q = t / 240;
         15: q = t / 272;
         16: q = t / 306;
         17: q = t / 342;
         18: q = t / 380;
         19: q = t / 420;
         default: q = t;
      endcase
      return q;
   endfunction

   // Q1.14 cosine of a 32-bit phase fraction; quadrant fold plus Q30 series
   function automatic logic signed [COEF_W-1:0] cos_entry(input logic [31:0] p);
      logic   [1:0] quad;
      logic         odd;
      logic         neg;
      longint       r;
      longint       x;
      longint       term;
      longint       sum;
      longint       mag;
      int           n;
      quad = p[31:30];
      odd  = quad[0];
      neg  = quad[1] ^ quad[0];
      r    = longint'({34'd0, p[29:0]});
      x    = (r * HALF_PI_Q30) >>> 30;
      term = odd ? x : Q30_ONE;
      sum  = term;
      n    = odd ? 1 : 0;
      for (int i = 0; i < 10; i++) begin
         term = (term * x) >>> 30;
         term = (term * x) >>> 30;
         term = taylor_div(term, n);
         n    = n + 2;
         if (i[0]) begin
            sum = sum + term;
         end else begin
            sum = sum - term;
         end
      end
      if (sum < 0) begin
         sum = 0;
      end
      mag = (sum + 64'sd32768) >>> 16;
      if (mag > 64'sd16384) begin
         mag = 64'sd16384;
      end
      return neg ? COEF_W'(-mag) : COEF_W'(mag);
   endfunction

endpackage

[rtl/core/dsbcd_delay.sv]
module dsbcd_delay #(
   parameter int WINDOW = dsbcd_pkg::WINDOW_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 wr_en,
   input  logic signed [dsbcd_pkg::SAMPLE_W-1:0] wr_data,
   output logic signed [dsbcd_pkg::SAMPLE_W-1:0] rd_data
);

   localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;

   logic signed [dsbcd_pkg::SAMPLE_W-1:0] mem_ff [WINDOW];
   logic signed [dsbcd_pkg::SAMPLE_W-1:0] rd_q_ff;
   logic [IDX_W-1:0]                      idx_ff;
   logic                                  wrapped_ff;

   // entries are zero until the first full pass
   assign rd_data = wrapped_ff ? rd_q_ff : '0;

   always_ff @(posedge clock) begin
      rd_q_ff <= mem_ff[idx_ff];
      if (wr_en) begin
         mem_ff[idx_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff     <= '0;
         wrapped_ff <= 1'b0;
      end else if (wr_en) begin
         if (idx_ff == IDX_W'(WINDOW - 1)) begin
            idx_ff     <= '0;
            wrapped_ff <= 1'b1;
         end else begin
            idx_ff <= idx_ff + 1'b1;
         end
      end
   end

endmodule

[rtl/core/dsb_coherent_demod_moving_average.sv]
// Channel   Direction  Handshake              Payload
// req_      in         req_valid / req_stall  req_sample_in
// rsp_      out        rsp_valid / rsp_stall  rsp_demod_sample, rsp_filtered_sample,
//                                             rsp_energy_total
// csr_      in         csr_wr_en              csr_index, csr_wr_data
//
// Per sample, one shared multiplier with a registered product
// is used four times in turn (gain, cosine, window divide, square).
// The result sits in an output register; the next sample is taken while it waits,
// and the last step holds only while an earlier result is still stalled.
// Synchronous reset; the delay line reads as zero until its first full pass.
module dsb_coherent_demod_moving_average #(
   parameter int WINDOW          = dsbcd_pkg::WINDOW_DEFAULT,
   parameter int COS_TABLE_DEPTH = dsbcd_pkg::COS_DEPTH_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [dsbcd_pkg::SAMPLE_W-1:0]  req_sample_in,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [dsbcd_pkg::SAMPLE_W-1:0]  rsp_demod_sample,
   output logic signed [dsbcd_pkg::SAMPLE_W-1:0]  rsp_filtered_sample,
   output logic        [dsbcd_pkg::ENERGY_W-1:0]  rsp_energy_total,
   input  logic                                   csr_wr_en,
   input  logic        [dsbcd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic        [dsbcd_pkg::CSR_DATA_W-1:0]  csr_wr_data
);

   localparam int SW     = dsbcd_pkg::SAMPLE_W;
   localparam int EW     = dsbcd_pkg::ENERGY_W;
   localparam int CW     = dsbcd_pkg::COEF_W;
   localparam int IDX_W  = $clog2(COS_TABLE_DEPTH);
   localparam int CLOG_W = $clog2(WINDOW);
   localparam int SUM_W  = SW + CLOG_W;
   localparam int UW     = 17 + CLOG_W;
   localparam int SHIFT  = UW + $clog2(2 * WINDOW);
   localparam int MW     = UW + 2;
   localparam int PW     = 2 * MW;
   localparam longint DIVISOR    = 2 * WINDOW;
   localparam longint DIV_OFFSET = longint'(WINDOW) * 65537;
   localparam longint RECIP      = ((64'sd1 <<< SHIFT) + DIVISOR - 1) / DIVISOR;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_AMP,
      ST_AMP,
      ST_MUL_DEMOD,
      ST_DEMOD,
      ST_DIV,
      ST_MUL_DIV,
      ST_FILT,
      ST_MUL_SQ,
      ST_ENERGY
   } state_type;

   state_type                 state_ff;
   logic [CW-1:0]             gain_ff;
   logic [CW-1:0]             phase_step_ff;
   logic [15:0]               phase_ff;
   logic signed [CW-1:0]      cos_ff;
   logic signed [MW-1:0]      opa_ff;
   logic signed [MW-1:0]      opb_ff;
   logic signed [PW-1:0]      prod_ff;
   logic signed [SUM_W-1:0]   sum_ff;
   logic signed [SW-1:0]      demod_ff;
   logic signed [SW-1:0]      filt_ff;
   logic [EW-1:0]             energy_ff;
   logic                      rsp_valid_ff;
   logic signed [SW-1:0]      rsp_demod_ff;
   logic signed [SW-1:0]      rsp_filt_ff;
   logic [EW-1:0]             rsp_energy_ff;

   logic signed [CW-1:0]      cos_rom [COS_TABLE_DEPTH];
   logic [16+IDX_W:0]         phase_scaled;
   logic [IDX_W-1:0]          cos_idx;
   logic                      accept;
   logic signed [PW-1:0]      amp_wide;
   logic signed [PW-1:0]      demod_wide;
   logic signed [SW-1:0]      amp;
   logic signed [SW-1:0]      demod;
   logic signed [SW-1:0]      old_sample;
   logic signed [UW:0]        u_wide;
   logic [15:0]               quot;
   logic signed [SW-1:0]      filt;
   logic [EW:0]               energy_sum;

   function automatic logic signed [SW-1:0] sat16(input logic signed [PW-1:0] v);
      logic signed [SW-1:0] r;
      if (v > PW'(32767)) begin
         r = 16'sh7FFF;
      end else if (v < -PW'(32768)) begin
         r = -16'sh8000;
      end else begin
         r = v[SW-1:0];
      end
      return r;
   endfunction

   for (genvar k = 0; k < COS_TABLE_DEPTH; k++) begin : g_cos
      localparam longint FRAC = (longint'(k) <<< 32) / COS_TABLE_DEPTH;
      assign cos_rom[k] = dsbcd_pkg::cos_entry(32'(FRAC));
   end

   assign accept       = req_valid && !req_stall;
   assign req_stall    = (state_ff != ST_IDLE);
   assign phase_scaled = (17 + IDX_W)'(phase_ff) * (17 + IDX_W)'(COS_TABLE_DEPTH);
   assign cos_idx      = phase_scaled[16+IDX_W-1:16];

   assign amp_wide   = (prod_ff + PW'(128)) >>> 8;
   assign demod_wide = (prod_ff + PW'(8192)) >>> 14;
   assign amp        = sat16(amp_wide);
   assign demod      = sat16(demod_wide);
   // offset by half the output range so the dividend is never negative
   assign u_wide     = ((UW + 1)'(sum_ff) <<< 1) + (UW + 1)'(DIV_OFFSET);
   assign quot       = prod_ff[SHIFT+15:SHIFT];
   assign filt       = {~quot[15], quot[14:0]};
   assign energy_sum = {1'b0, energy_ff} + (EW + 1)'(prod_ff[31:0]);

   dsbcd_delay #(
      .WINDOW (WINDOW)
   ) u_delay (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (state_ff == ST_DEMOD),
      .wr_data (demod),
      .rd_data (old_sample)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff       <= dsbcd_pkg::GAIN_RESET;
         phase_step_ff <= dsbcd_pkg::PHASE_STEP_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            dsbcd_pkg::CSR_GAIN:       gain_ff       <= csr_wr_data;
            dsbcd_pkg::CSR_PHASE_STEP: phase_step_ff <= csr_wr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= opa_ff * opb_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= '0;
         sum_ff       <= '0;
         energy_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall && state_ff != ST_ENERGY) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  opa_ff   <= MW'(req_sample_in);
                  opb_ff   <= MW'({1'b0, gain_ff});
                  cos_ff   <= cos_rom[cos_idx];
                  phase_ff <= phase_ff + phase_step_ff;
                  state_ff <= ST_MUL_AMP;
               end
            end
            ST_MUL_AMP: state_ff <= ST_AMP;
            ST_AMP: begin
               opa_ff   <= MW'(amp);
               opb_ff   <= MW'(cos_ff);
               state_ff <= ST_MUL_DEMOD;
            end
            ST_MUL_DEMOD: state_ff <= ST_DEMOD;
            ST_DEMOD: begin
               demod_ff <= demod;
               sum_ff   <= sum_ff - SUM_W'(old_sample) + SUM_W'(demod);
               state_ff <= ST_DIV;
            end
            ST_DIV: begin
               opa_ff   <= MW'(u_wide);
               opb_ff   <= MW'(RECIP);
               state_ff <= ST_MUL_DIV;
            end
            ST_MUL_DIV: state_ff <= ST_FILT;
            ST_FILT: begin
               filt_ff  <= filt;
               opa_ff   <= MW'(filt);
               opb_ff   <= MW'(filt);
               state_ff <= ST_MUL_SQ;
            end
            ST_MUL_SQ: state_ff <= ST_ENERGY;
            ST_ENERGY: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  energy_ff     <= energy_sum[EW] ? '1 : energy_sum[EW-1:0];
                  rsp_energy_ff <= energy_sum[EW] ? '1 : energy_sum[EW-1:0];
                  rsp_demod_ff  <= demod_ff;
                  rsp_filt_ff   <= filt_ff;
                  rsp_valid_ff  <= 1'b1;
                  state_ff      <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_demod_sample    = rsp_demod_ff;
   assign rsp_filtered_sample = rsp_filt_ff;
   assign rsp_energy_total    = rsp_energy_ff;

`ifndef ASSERT_OFF
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> req_stall)
      else $error("input taken while a sample is in flight");

   a_energy_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> energy_ff >= $past(energy_ff))
      else $error("energy accumulator decreased");

   a_cos_index_range: assert property (@(posedge clock) disable iff (reset)
      accept |-> (32'(cos_idx) < COS_TABLE_DEPTH))
      else $error("cosine index beyond table");

   a_result_from_last_step: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff) == ST_ENERGY)
      else $error("result raised outside the final step");
`endif

endmodule

[tb/dsb_coherent_demod_moving_average_test.sv]
module dsb_coherent_demod_moving_average_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WINDOW          = dsbcd_pkg::WINDOW_DEFAULT;
   localparam int COS_DEPTH       = dsbcd_pkg::COS_DEPTH_DEFAULT;
   localparam int SAMPLE_W        = dsbcd_pkg::SAMPLE_W;
   localparam int ENERGY_W        = dsbcd_pkg::ENERGY_W;
   localparam int CSR_INDEX_W     = dsbcd_pkg::CSR_INDEX_W;
   localparam int CSR_DATA_W      = dsbcd_pkg::CSR_DATA_W;
   localparam int RANDOM_PHASES   = 6;
   localparam int SAMPLES_PER_RUN = 146;
   localparam int SETTLE_CYCLES   = 24;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int HOLD_OFF_AFTER  = 420;
   localparam int WATCHDOG_LIMIT  = 4000;
   localparam logic [63:0] ENERGY_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

   typedef logic signed [SAMPLE_W-1:0] sample_type;

   typedef struct packed {
      sample_type            demod;
      sample_type            filtered;
      logic [ENERGY_W-1:0]   energy;
   } demod_result_type;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   sample_type             req_sample_in;
   logic                   rsp_valid;
   logic                   rsp_stall;
   sample_type             rsp_demod_sample;
   sample_type             rsp_filtered_sample;
   logic [ENERGY_W-1:0]    rsp_energy_total;
   logic                   csr_wr_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wr_data;

   int samples_sent;
   int idle_cycles;

   class demod_scoreboard;
      demod_result_type    pending_results[$];
      sample_type          cos_lut[COS_DEPTH];
      int                  delay_line[WINDOW];
      longint              window_sum;
      int                  write_pos;
      logic [15:0]         carrier_phase;
      logic [15:0]         gain;
      logic [15:0]         phase_step;
      logic [ENERGY_W-1:0] energy_acc;
      int                  mismatches;

      function new();
         for (int k = 0; k < COS_DEPTH; k++) begin
            cos_lut[k] = carrier_cos(k);
         end
         foreach (delay_line[i]) begin
            delay_line[i] = 0;
         end
         window_sum    = 0;
         write_pos     = 0;
         carrier_phase = '0;
         energy_acc    = '0;
         gain          = dsbcd_pkg::GAIN_RESET;
         phase_step    = dsbcd_pkg::PHASE_STEP_RESET;
         mismatches    = 0;
      endfunction

      // quadrant fold, then a Q30 power series, rounded to Q1.14
      function sample_type carrier_cos(int k);
         logic [63:0] frac;
         logic [31:0] p;
         longint      x;
         longint      term;
         longint      sum;
         longint      mag;
         int          n;
         sample_type  v;
         frac = (64'(k) << 32) / COS_DEPTH;
         p    = frac[31:0];
         x    = (longint'({34'd0, p[29:0]}) * 64'sd1686629713) >>> 30;
         term = p[30] ? x : 64'sd1073741824;
         sum  = term;
         n    = p[30] ? 1 : 0;
         for (int i = 0; i < 10; i++) begin
            term = (term * x) >>> 30;
            term = (term * x) >>> 30;
            term = term / longint'((n + 1) * (n + 2));
            n    = n + 2;
            if (i % 2 == 1) begin
               sum = sum + term;
            end else begin
               sum = sum - term;
            end
         end
         if (sum < 0) begin
            sum = 0;
         end
         mag = (sum + 32768) >>> 16;
         if (mag > 16384) begin
            mag = 16384;
         end
         v = mag[15:0];
         return (p[31] ^ p[30]) ? -v : v;
      endfunction

      function longint clamp16(longint v);
         if (v > 32767) begin
            return 32767;
         end
         if (v < -32768) begin
            return -32768;
         end
         return v;
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         if (idx == dsbcd_pkg::CSR_GAIN) begin
            gain = data;
         end else if (idx == dsbcd_pkg::CSR_PHASE_STEP) begin
            phase_step = data;
         end
      endfunction

      function void take_sample(sample_type s);
         longint           amp;
         longint           demod;
         longint           num;
         longint           filt;
         logic [63:0]      sq;
         int               idx;
         demod_result_type r;
         amp = clamp16((longint'(s) * longint'({48'd0, gain}) + 128) >>> 8);
         idx = (int'({16'd0, carrier_phase}) * COS_DEPTH) >>> 16;
         if (idx >= COS_DEPTH) begin
            idx = COS_DEPTH - 1;
         end
         demod = clamp16((amp * longint'(cos_lut[idx]) + 8192) >>> 14);
         carrier_phase = carrier_phase + phase_step;

         window_sum = window_sum - delay_line[write_pos] + demod;
         delay_line[write_pos] = int'(demod);
         write_pos = (write_pos + 1) % WINDOW;

         // round half up, floor for negative sums
         num = 2 * window_sum + WINDOW;
         if (num >= 0) begin
            filt = num / (2 * WINDOW);
         end else begin
            filt = -((-num - 1) / (2 * WINDOW)) - 1;
         end
         filt = clamp16(filt);

         sq = 64'(filt * filt);
         if ({1'b0, energy_acc} > ENERGY_MAX - sq) begin
            energy_acc = ENERGY_MAX[ENERGY_W-1:0];
         end else begin
            energy_acc = energy_acc + sq[ENERGY_W-1:0];
         end

         r.demod    = demod[15:0];
         r.filtered = filt[15:0];
         r.energy   = energy_acc;
         pending_results.push_back(r);
      endfunction

      function void check_result(sample_type d, sample_type f, logic [ENERGY_W-1:0] e);
         demod_result_type want;
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("%0t: unexpected result demod=%0d filtered=%0d energy=%0d",
                        $realtime, d, f, e);
            end
            return;
         end
         want = pending_results.pop_front();
         if (want.demod !== d || want.filtered !== f || want.energy !== e) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("%0t: mismatch demod exp %0d got %0d, filtered exp %0d got %0d, %s",
                        $realtime, want.demod, d, want.filtered, f, "energy below");
               $display("   energy exp %0d got %0d", want.energy, e);
            end
         end
      endfunction
   endclass

   demod_scoreboard board;

   dsb_coherent_demod_moving_average i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_sample_in       (req_sample_in),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_demod_sample    (rsp_demod_sample),
      .rsp_filtered_sample (rsp_filtered_sample),
      .rsp_energy_total    (rsp_energy_total),
      .csr_wr_en           (csr_wr_en),
      .csr_index           (csr_index),
      .csr_wr_data         (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         board.check_result(rsp_demod_sample, rsp_filtered_sample, rsp_energy_total);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("dsb_coherent_demod_moving_average_test: FAIL");
            $finish;
         end
      end
   end

   // receiver pacing; one long hold-off to back the block up
   initial begin : rsp_pacing
      int span;
      int odds;
      bit hold_done;
      hold_done = 1'b0;
      forever begin
         if (!hold_done && samples_sent >= HOLD_OFF_AFTER) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            hold_done = 1'b1;
         end
         span = $urandom_range(4, 60);
         odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 80);
         repeat (span) begin
            rsp_stall <= ($urandom_range(0, 99) < odds);
            @(posedge clock);
         end
      end
   end

   task automatic send_sample(input sample_type s);
      req_valid     <= 1'b1;
      req_sample_in <= s;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      board.take_sample(s);
      samples_sent++;
   endtask

   task automatic play_samples(input sample_type samples[$], input bit steady);
      int burst;
      int gap;
      burst = $urandom_range(1, 24);
      foreach (samples[i]) begin
         send_sample(samples[i]);
         burst--;
         if (i == samples.size() - 1) begin
            req_valid <= 1'b0;
         end else if (burst == 0 && !steady) begin
            burst = $urandom_range(1, 24);
            gap   = $urandom_range(0, 10);
            if (gap > 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
      end
   endtask

   task automatic drain;
      while (board.pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic configure(input logic [CSR_DATA_W-1:0] g, input logic [CSR_DATA_W-1:0] step);
      csr_wr_en   <= 1'b1;
      csr_index   <= dsbcd_pkg::CSR_GAIN;
      csr_wr_data <= g;
      @(posedge clock);
      board.write_reg(dsbcd_pkg::CSR_GAIN, g);
      csr_index   <= dsbcd_pkg::CSR_PHASE_STEP;
      csr_wr_data <= step;
      @(posedge clock);
      board.write_reg(dsbcd_pkg::CSR_PHASE_STEP, step);
      csr_wr_en <= 1'b0;
   endtask

   function automatic sample_type pick_sample();
      int unsigned pick;
      pick = $urandom_range(0, 19);
      if (pick < 2) begin
         return 16'sh7FFF;
      end else if (pick < 4) begin
         return 16'sh8000;
      end else if (pick < 7) begin
         return sample_type'(int'($urandom_range(0, 1023)) - 512);
      end
      return sample_type'($urandom);
   endfunction

   initial begin : stimulus
      sample_type            stream[$];
      logic [CSR_DATA_W-1:0] g;
      logic [CSR_DATA_W-1:0] step;
      bit                    steady;
      board         = new();
      samples_sent  = 0;
      idle_cycles   = 0;
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_sample_in <= '0;
      csr_wr_en     <= 1'b0;
      csr_index     <= dsbcd_pkg::CSR_GAIN;
      csr_wr_data   <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: extremes and signs
      stream = '{16'sd0, 16'sd1, -16'sd1, 16'sh7FFF, 16'sh8000, 16'sd4096, -16'sd4096,
                 16'sd12345, -16'sd12345, 16'sh7FFF};
      play_samples(stream, 1'b0);
      drain();

      // full gain, fixed phase: demod saturates both ways
      configure(16'hFFFF, 16'h0000);
      stream = '{16'sh7FFF, 16'sh8000, 16'sd1, -16'sd1, 16'sd0, 16'sd128};
      play_samples(stream, 1'b0);
      drain();

      // zero gain, half-cycle carrier
      configure(16'h0000, 16'h8000);
      stream = '{16'sh7FFF, 16'sh8000, 16'sd777, -16'sd777};
      play_samples(stream, 1'b1);
      drain();

      // unity gain, largest step
      configure(16'h0100, 16'hFFFF);
      stream = '{16'sh7FFF, 16'sh8000, 16'sd4096, -16'sd4096, 16'sd3};
      play_samples(stream, 1'b0);
      drain();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         steady = 1'b0;
         case (p)
            0: begin
               g    = 16'($urandom_range(0, 65535));
               step = 16'($urandom_range(0, 65535));
            end
            1: begin
               g    = 16'hFFFF;
               step = 16'($urandom_range(0, 65535));
            end
            2: begin
               g      = 16'h0100;
               step   = 16'h0000;
               steady = 1'b1;
            end
            3: begin
               g    = 16'($urandom_range(0, 1023));
               step = 16'h8000;
            end
            4: begin
               g    = 16'($urandom_range(512, 4096));
               step = 16'($urandom_range(1, 2000));
            end
            default: begin
               g    = dsbcd_pkg::GAIN_RESET;
               step = dsbcd_pkg::PHASE_STEP_RESET;
            end
         endcase
         configure(g, step);
         stream.delete();
         repeat (SAMPLES_PER_RUN) stream.push_back(pick_sample());
         play_samples(stream, steady);
         drain();
      end

      repeat (40) @(posedge clock);
      if (board.mismatches == 0 && board.pending_results.size() == 0) begin
         $display("dsb_coherent_demod_moving_average_test: PASS");
      end else begin
         $display("dsb_coherent_demod_moving_average_test: FAIL");
      end
      $finish;
   end

endmodule
